// ===== design/frm_pkg.sv =====
// Shared constants, types and the control program of the frame rate meter.
`timescale 1ns / 1ps
`default_nettype none

package frm_pkg;

    // Window length and time base
    localparam int WINDOW    = 10;
    localparam int TIME_BITS = 32;

    // Field widths
    localparam int NOW_W   = 32;
    localparam int FPS_W   = 28;
    localparam int FT_W    = 32;
    localparam int DELAY_W = 18;
    localparam int CAP_W   = 18;

    // Derived widths
    localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int FILL_W = $clog2(WINDOW + 1);
    localparam int SUM_W  = TIME_BITS + $clog2(WINDOW);
    localparam int PROD_W = TIME_BITS + CAP_W;

    // Fixed point constants: 1000 ms in Q.8 and the default 60.0 fps
    localparam int MS_Q8          = 256000;
    localparam int DEFAULT_FPS_Q8 = 15360;

    // Serial divider sizing
    localparam int FPS_DIV_W = $clog2(MS_Q8 * WINDOW + 1);
    localparam int DLY_DIV_W = $clog2(MS_Q8 + 1);
    localparam int DIVN      = (FPS_DIV_W > DLY_DIV_W) ? FPS_DIV_W : DLY_DIV_W;
    localparam int DCNT_W    = $clog2(DIVN + 1);

    // Configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic [APB_ADDR_W-1:0] ADDR_MAX_FPS = 3'd0;

    // Sequencer
    localparam int PC_W     = 4;
    localparam int PROG_LEN = 9;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_ACCEPT,
        OP_SUB_OLD,
        OP_ADD_NEW,
        OP_MUL,
        OP_FPS_LOAD,
        OP_DIV_STEP,
        OP_FPS_TAKE,
        OP_FINISH
    } op_t;

    typedef enum logic [2:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_NO_IN,
        COND_DIV_MORE,
        COND_OUT_FULL
    } cond_t;

    typedef struct packed {
        op_t              op;
        cond_t            cond;
        logic [PC_W-1:0]  target;
    } ctrl_t;

    // Control store: jump to target when the condition holds, else step on
    function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
        ctrl_t w;
        unique case (pc)
            4'd0:    w = '{op: OP_ACCEPT,   cond: COND_NO_IN,    target: 4'd0};
            4'd1:    w = '{op: OP_SUB_OLD,  cond: COND_NEVER,    target: 4'd0};
            4'd2:    w = '{op: OP_ADD_NEW,  cond: COND_NEVER,    target: 4'd0};
            4'd3:    w = '{op: OP_MUL,      cond: COND_NEVER,    target: 4'd0};
            4'd4:    w = '{op: OP_FPS_LOAD, cond: COND_NEVER,    target: 4'd0};
            4'd5:    w = '{op: OP_DIV_STEP, cond: COND_DIV_MORE, target: 4'd5};
            4'd6:    w = '{op: OP_FPS_TAKE, cond: COND_NEVER,    target: 4'd0};
            4'd7:    w = '{op: OP_DIV_STEP, cond: COND_DIV_MORE, target: 4'd7};
            4'd8:    w = '{op: OP_FINISH,   cond: COND_OUT_FULL, target: 4'd8};
            default: w = '{op: OP_NOP,      cond: COND_ALWAYS,   target: 4'd0};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ===== design/frm_evt_if.sv =====
// Frame-end event channel: valid/ready handshake with the two time stamps.
`timescale 1ns / 1ps
`default_nettype none

interface frm_evt_if import frm_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [NOW_W-1:0] now_ms;
    logic [NOW_W-1:0] frame_start_ms;

    modport source (output valid, output now_ms, output frame_start_ms, input ready);
    modport sink (input valid, input now_ms, input frame_start_ms, output ready);
endinterface

`default_nettype wire

// ===== design/frm_res_if.sv =====
// Result channel: valid/ready handshake with rate, interval and wait.
`timescale 1ns / 1ps
`default_nettype none

interface frm_res_if import frm_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [FPS_W-1:0]   fps_q8;
    logic [FT_W-1:0]    frame_time_ms;
    logic [DELAY_W-1:0] delay_ms;

    modport source (output valid, output fps_q8, output frame_time_ms, output delay_ms,
                    input ready);
    modport sink (input valid, input fps_q8, input frame_time_ms, input delay_ms,
                  output ready);
endinterface

`default_nettype wire

// ===== design/frame_rate_meter_limiter.sv =====
// Top level: microcoded moving-average frame rate meter with a rate cap.
//
//   channel  | direction | handshake      | contents
//   ---------+-----------+----------------+-----------------------------------------
//   events   | in        | valid/ready    | now_ms, frame_start_ms
//   results  | out       | valid/ready    | fps_q8, frame_time_ms, delay_ms
//   apb      | in        | psel/penable   | max_fps_q8 at byte address 0
//
// The shared restoring divider runs one quotient bit a cycle, first for the
// rate, then for the wait budget. The next event can be taken from the cycle
// after the result is loaded into the output register. rst_n clears the
// window, the sequencer and the output valid flag; the output register holds
// a result until it is taken, and the sequencer waits at its last step only
// while that register is full and not being taken.
`timescale 1ns / 1ps
`default_nettype none

module frame_rate_meter_limiter import frm_pkg::*; (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    frm_evt_if.sink                    events,
    frm_res_if.source                  results,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready
);

    // Control state
    logic [PC_W-1:0]      pc_reg, pc_next;
    logic                 seen_first_reg, seen_first_next;
    logic [FILL_W-1:0]    fill_reg, fill_next;
    logic [SLOT_W-1:0]    slot_reg, slot_next;
    logic [SUM_W-1:0]     sum_reg, sum_next;
    logic [TIME_BITS-1:0] last_time_reg, last_time_next;
    logic [CAP_W-1:0]     max_fps_reg;
    logic                 out_valid_reg, out_valid_next;
    logic [DCNT_W-1:0]    div_cnt_reg, div_cnt_next;

    // Datapath
    logic [TIME_BITS-1:0] ring_reg [WINDOW];
    logic                 ring_we;
    logic [TIME_BITS-1:0] interval_reg, interval_next;
    logic [TIME_BITS-1:0] elapsed_reg, elapsed_next;
    logic [CAP_W-1:0]     cap_reg, cap_next;
    logic [PROD_W-1:0]    prod_reg, prod_next;
    logic [DIVN-1:0]      div_q_reg, div_q_next;
    logic [SUM_W-1:0]     div_r_reg, div_r_next;
    logic [SUM_W-1:0]     div_d_reg, div_d_next;
    logic [FPS_W-1:0]     fps_reg, fps_next;
    logic                 delay_ok_reg, delay_ok_next;
    logic [FPS_W-1:0]     out_fps_reg, out_fps_next;
    logic [FT_W-1:0]      out_ft_reg, out_ft_next;
    logic [DELAY_W-1:0]   out_delay_reg, out_delay_next;

    ctrl_t                ctrl;
    logic                 jump;
    logic                 in_take;
    logic                 out_free;
    logic                 cfg_write;
    logic [TIME_BITS-1:0] now_t;
    logic [TIME_BITS-1:0] start_t;
    logic [SUM_W:0]       rem_sh;
    logic                 rem_ge;

    // Configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr == ADDR_MAX_FPS) ? APB_DATA_W'(max_fps_reg) : '0;

    // Handshakes
    assign ctrl           = ucode(pc_reg);
    assign events.ready   = (ctrl.op == OP_ACCEPT);
    assign in_take        = events.valid && events.ready;
    assign out_free       = !out_valid_reg || results.ready;
    assign results.valid  = out_valid_reg;
    assign results.fps_q8        = out_fps_reg;
    assign results.frame_time_ms = out_ft_reg;
    assign results.delay_ms      = out_delay_reg;

    assign now_t   = TIME_BITS'(events.now_ms);
    assign start_t = TIME_BITS'(events.frame_start_ms);

    // Divider step: shift in the next dividend bit, subtract when it fits
    assign rem_sh = {div_r_reg, div_q_reg[DIVN-1]};
    assign rem_ge = (rem_sh >= {1'b0, div_d_reg});

    // Branch condition
    always_comb
    begin
        unique case (ctrl.cond)
            COND_NEVER:    jump = 1'b0;
            COND_ALWAYS:   jump = 1'b1;
            COND_NO_IN:    jump = !in_take;
            COND_DIV_MORE: jump = (div_cnt_reg != DCNT_W'(1));
            COND_OUT_FULL: jump = !out_free;
            default:       jump = 1'b0;
        endcase
    end

    // Step counter
    always_comb
    begin
        if (jump)
            pc_next = ctrl.target;
        else if (pc_reg == PC_W'(PROG_LEN - 1))
            pc_next = '0;
        else
            pc_next = pc_reg + PC_W'(1);
    end

    // Datapath driven by the control word
    always_comb
    begin
        seen_first_next = seen_first_reg;
        fill_next       = fill_reg;
        slot_next       = slot_reg;
        sum_next        = sum_reg;
        last_time_next  = last_time_reg;
        out_valid_next  = out_valid_reg && !results.ready;
        div_cnt_next    = div_cnt_reg;
        ring_we         = 1'b0;
        interval_next   = interval_reg;
        elapsed_next    = elapsed_reg;
        cap_next        = cap_reg;
        prod_next       = prod_reg;
        div_q_next      = div_q_reg;
        div_r_next      = div_r_reg;
        div_d_next      = div_d_reg;
        fps_next        = fps_reg;
        delay_ok_next   = delay_ok_reg;
        out_fps_next    = out_fps_reg;
        out_ft_next     = out_ft_reg;
        out_delay_next  = out_delay_reg;

        unique case (ctrl.op)
            OP_NOP:
            begin
            end
            // Take the event: interval since the last one, elapsed frame time
            OP_ACCEPT:
            begin
                if (in_take)
                begin
                    interval_next   = seen_first_reg ? (now_t - last_time_reg) : '0;
                    elapsed_next    = now_t - start_t;
                    last_time_next  = now_t;
                    seen_first_next = 1'b1;
                end
            end
            // Drop the oldest interval once the window is full, else grow it
            OP_SUB_OLD:
            begin
                if (fill_reg == FILL_W'(WINDOW))
                    sum_next = sum_reg - SUM_W'(ring_reg[slot_reg]);
                else
                    fill_next = fill_reg + FILL_W'(1);
            end
            // Store the new interval and advance the write slot
            OP_ADD_NEW:
            begin
                ring_we  = 1'b1;
                sum_next = sum_reg + SUM_W'(interval_reg);
                if (slot_reg == SLOT_W'(WINDOW - 1))
                    slot_next = '0;
                else
                    slot_next = slot_reg + SLOT_W'(1);
            end
            // Elapsed time times the cap, a zero cap counting as one
            OP_MUL:
            begin
                cap_next  = (max_fps_reg == '0) ? CAP_W'(1) : max_fps_reg;
                prod_next = PROD_W'(elapsed_reg) *
                            PROD_W'((max_fps_reg == '0) ? CAP_W'(1) : max_fps_reg);
            end
            // Start 256000*count / sum
            OP_FPS_LOAD:
            begin
                div_q_next   = (DIVN'(MS_Q8) * DIVN'(fill_reg)) << (DIVN - FPS_DIV_W);
                div_r_next   = '0;
                div_d_next   = sum_reg;
                div_cnt_next = DCNT_W'(FPS_DIV_W);
            end
            OP_DIV_STEP:
            begin
                div_q_next   = {div_q_reg[DIVN-2:0], rem_ge};
                div_r_next   = rem_ge ? SUM_W'(rem_sh - {1'b0, div_d_reg})
                                      : SUM_W'(rem_sh);
                div_cnt_next = div_cnt_reg - DCNT_W'(1);
            end
            // Hold the rate, then start 256000 / cap
            OP_FPS_TAKE:
            begin
                fps_next      = (sum_reg == '0) ? FPS_W'(DEFAULT_FPS_Q8)
                                                : FPS_W'(div_q_reg[FPS_DIV_W-1:0]);
                delay_ok_next = (prod_reg < PROD_W'(MS_Q8));
                div_q_next    = DIVN'(MS_Q8) << (DIVN - DLY_DIV_W);
                div_r_next    = '0;
                div_d_next    = SUM_W'(cap_reg);
                div_cnt_next  = DCNT_W'(DLY_DIV_W);
            end
            // Load the output register once it is free
            OP_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_fps_next   = fps_reg;
                    out_ft_next    = FT_W'(interval_reg);
                    out_delay_next = delay_ok_reg
                        ? DELAY_W'(div_q_reg[DLY_DIV_W-1:0]) - DELAY_W'(elapsed_reg)
                        : '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg         <= '0;
            seen_first_reg <= 1'b0;
            fill_reg       <= '0;
            slot_reg       <= '0;
            sum_reg        <= '0;
            last_time_reg  <= '0;
            max_fps_reg    <= CAP_W'(DEFAULT_FPS_Q8);
            out_valid_reg  <= 1'b0;
            div_cnt_reg    <= '0;
        end
        else
        begin
            pc_reg         <= pc_next;
            seen_first_reg <= seen_first_next;
            fill_reg       <= fill_next;
            slot_reg       <= slot_next;
            sum_reg        <= sum_next;
            last_time_reg  <= last_time_next;
            out_valid_reg  <= out_valid_next;
            div_cnt_reg    <= div_cnt_next;
            if (cfg_write && (paddr == ADDR_MAX_FPS))
                max_fps_reg <= pwdata[CAP_W-1:0];
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (ring_we)
            ring_reg[slot_reg] <= interval_reg;
        interval_reg  <= interval_next;
        elapsed_reg   <= elapsed_next;
        cap_reg       <= cap_next;
        prod_reg      <= prod_next;
        div_q_reg     <= div_q_next;
        div_r_reg     <= div_r_next;
        div_d_reg     <= div_d_next;
        fps_reg       <= fps_next;
        delay_ok_reg  <= delay_ok_next;
        out_fps_reg   <= out_fps_next;
        out_ft_reg    <= out_ft_next;
        out_delay_reg <= out_delay_next;
    end

endmodule

`default_nettype wire
